// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of the playlist sequencer.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SHPL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shpl assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SHPL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shpl assertion failed");

`endif

// ===== src/shpl_pkg.sv =====
// Package of the playlist sequencer: field widths, command and mode codes,
// controller state and datapath operation types, and the random step.
// No dependencies.
package shpl_pkg;

  localparam int SHPL_MAX_TRACKS = 512;
  localparam int CMD_W           = 3;
  localparam int SEL_W           = 9;
  localparam int TRACK_W         = 9;
  localparam int MODE_W          = 2;
  localparam int TC_W            = 10;
  localparam int RNG_W           = 32;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 32;

  localparam logic [CMD_W-1:0] CMD_START      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_NEXT       = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PREV       = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TRACK_END  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CYCLE_MODE = 3'd4;

  localparam logic [MODE_W-1:0] MODE_LIST_LOOP   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SHUFFLE     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SINGLE_LOOP = 2'd2;
  localparam logic [MODE_W-1:0] MODE_LIST_PLAY   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RNG_SEED    = 1'd1;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_MODE_PIN, S_FILL, S_SWAP_CHK, S_RNG_WAIT, S_RD_I, S_RD_J,
    S_WR_I, S_WR_J, S_FIND_RD, S_FIND_CMP, S_STEP, S_POS1, S_RD_POS, S_MOD_ENT,
    S_MOD_WAIT, S_ADJ, S_DONE
  } shpl_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_START_SEL, OP_PIN_CUR, OP_MODE_INC, OP_FILL, OP_MOD_RNG,
    OP_RD_I, OP_RD_J, OP_WR_I, OP_WR_J, OP_POS_CLR, OP_FIND_INIT, OP_FIND_RD,
    OP_FIND_CMP, OP_POS_FWD, OP_POS_BACK, OP_POS_ONE, OP_RD_POS, OP_MOD_CUR,
    OP_MOD_ENT, OP_SET_CUR, OP_CUR_NEXT, OP_CUR_PREV, OP_OUT
  } shpl_op_t;

  typedef struct packed {
    shpl_op_t op;
    logic     play_start;
  } shpl_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [MODE_W-1:0] mode;
    logic              n_le1;
    logic              i_le1;
    logic              hit;
    logic              k_last;
    logic              pos_last;
    logic              cur_lt_last;
    logic              mod_busy;
    logic              out_busy;
  } shpl_sts_t;

  function automatic logic [RNG_W-1:0] xorshift32(input logic [RNG_W-1:0] x);
    logic [RNG_W-1:0] v;
    v = x ^ (x << 13);
    v = v ^ (v >> 17);
    v = v ^ (v << 5);
    return v;
  endfunction

endpackage

// ===== src/shpl_if.sv =====
// Valid/ready channel interfaces of the playlist sequencer.
// Depends on shpl_pkg for the payload widths.
interface shpl_in_if import shpl_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [SEL_W-1:0] track_sel;
  modport source (output valid, cmd, track_sel, input ready);
  modport sink (input valid, cmd, track_sel, output ready);
endinterface

interface shpl_out_if import shpl_pkg::*;;
  logic               valid;
  logic               ready;
  logic [TRACK_W-1:0] track_index;
  logic               play_start;
  logic [MODE_W-1:0]  play_mode;
  modport source (output valid, track_index, play_start, play_mode, input ready);
  modport sink (input valid, track_index, play_start, play_mode, output ready);
endinterface

// ===== src/shpl_mod.sv =====
// Shared remainder unit: restoring division, one dividend bit per cycle.
// Depends on shpl_pkg for the dividend width.
module shpl_mod import shpl_pkg::*; #(
  parameter int DSR_W = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [RNG_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             busy,
  output logic [DSR_W-1:0] rem
);

  localparam int CNT_W = $clog2(RNG_W);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [RNG_W-1:0] dvd_r, dvd_nxt;
  logic [DSR_W-1:0] dsr_r, dsr_nxt;
  logic [DSR_W-1:0] rem_r, rem_nxt;
  logic [DSR_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[RNG_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(RNG_W - 1);
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = dvd_r << 1;
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = DSR_W'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = DSR_W'(trial);
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = busy_r;
  assign rem  = rem_r;

endmodule

// ===== src/shpl_ctrl.sv =====
// Controller of the playlist sequencer: sequences commands, reshuffles,
// order searches and remainders. Depends on shpl_pkg.
module shpl_ctrl import shpl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  shpl_sts_t sts,
  output shpl_ctl_t ctl
);

  shpl_state_t state_r, state_nxt;
  logic        start_r, start_nxt;
  logic        shuf;

  assign shuf = (sts.mode == MODE_SHUFFLE);

  always_comb begin
    state_nxt = state_r;
    start_nxt = start_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        start_nxt = 1'b1;
        case (sts.cmd)
          CMD_START: state_nxt = S_FILL;
          CMD_NEXT, CMD_PREV: begin
            state_nxt = (shuf && !sts.n_le1) ? S_FIND_RD : S_MOD_WAIT;
          end
          CMD_TRACK_END: begin
            if (sts.mode == MODE_LIST_PLAY) begin
              state_nxt = S_DONE;
              start_nxt = sts.cur_lt_last;
            end else begin
              state_nxt = (shuf && !sts.n_le1) ? S_FIND_RD : S_MOD_WAIT;
            end
          end
          CMD_CYCLE_MODE: begin
            start_nxt = 1'b0;
            state_nxt = (sts.mode == MODE_LIST_LOOP) ? S_MODE_PIN : S_DONE;
          end
          default: begin
            start_nxt = 1'b0;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_MODE_PIN: state_nxt = S_FILL;
      S_FILL: begin
        if (sts.k_last) state_nxt = S_SWAP_CHK;
      end
      S_SWAP_CHK: begin
        if (sts.i_le1) begin
          state_nxt = (sts.cmd == CMD_TRACK_END) ? S_POS1 : S_DONE;
        end else begin
          state_nxt = S_RNG_WAIT;
        end
      end
      S_RNG_WAIT: begin
        if (!sts.mod_busy) state_nxt = S_RD_I;
      end
      S_RD_I:     state_nxt = S_RD_J;
      S_RD_J:     state_nxt = S_WR_I;
      S_WR_I:     state_nxt = S_WR_J;
      S_WR_J:     state_nxt = S_SWAP_CHK;
      S_FIND_RD:  state_nxt = S_FIND_CMP;
      S_FIND_CMP: begin
        state_nxt = (sts.hit || sts.k_last) ? S_STEP : S_FIND_RD;
      end
      S_STEP: begin
        if (sts.cmd == CMD_TRACK_END && sts.pos_last) state_nxt = S_FILL;
        else state_nxt = S_RD_POS;
      end
      S_POS1:     state_nxt = S_RD_POS;
      S_RD_POS:   state_nxt = S_MOD_ENT;
      S_MOD_ENT:  state_nxt = S_MOD_WAIT;
      S_MOD_WAIT: begin
        if (!sts.mod_busy) state_nxt = S_ADJ;
      end
      S_ADJ:      state_nxt = S_DONE;
      S_DONE: begin
        if (!sts.out_busy) state_nxt = S_IDLE;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl.op         = OP_NONE;
    ctl.play_start = start_r;
    in_ready       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) ctl.op = OP_LATCH;
      end
      S_DECODE: begin
        case (sts.cmd)
          CMD_START: ctl.op = OP_START_SEL;
          CMD_NEXT, CMD_PREV: begin
            ctl.op = (shuf && !sts.n_le1) ? OP_FIND_INIT : OP_MOD_CUR;
          end
          CMD_TRACK_END: begin
            if (sts.mode == MODE_LIST_PLAY) begin
              ctl.op = sts.cur_lt_last ? OP_CUR_NEXT : OP_NONE;
            end else begin
              ctl.op = (shuf && !sts.n_le1) ? OP_FIND_INIT : OP_MOD_CUR;
            end
          end
          CMD_CYCLE_MODE: ctl.op = OP_MODE_INC;
          default:        ctl.op = OP_NONE;
        endcase
      end
      S_MODE_PIN: ctl.op = OP_PIN_CUR;
      S_FILL:     ctl.op = OP_FILL;
      S_SWAP_CHK: ctl.op = sts.i_le1 ? OP_POS_CLR : OP_MOD_RNG;
      S_RNG_WAIT: ctl.op = OP_NONE;
      S_RD_I:     ctl.op = OP_RD_I;
      S_RD_J:     ctl.op = OP_RD_J;
      S_WR_I:     ctl.op = OP_WR_I;
      S_WR_J:     ctl.op = OP_WR_J;
      S_FIND_RD:  ctl.op = OP_FIND_RD;
      S_FIND_CMP: ctl.op = OP_FIND_CMP;
      S_STEP: begin
        if (sts.cmd == CMD_PREV) ctl.op = OP_POS_BACK;
        else if (sts.cmd == CMD_TRACK_END && sts.pos_last) ctl.op = OP_PIN_CUR;
        else ctl.op = OP_POS_FWD;
      end
      S_POS1:     ctl.op = OP_POS_ONE;
      S_RD_POS:   ctl.op = OP_RD_POS;
      S_MOD_ENT:  ctl.op = OP_MOD_ENT;
      S_MOD_WAIT: ctl.op = sts.mod_busy ? OP_NONE : OP_SET_CUR;
      S_ADJ: begin
        if (!shuf) begin
          if (sts.cmd == CMD_NEXT ||
              (sts.cmd == CMD_TRACK_END && sts.mode == MODE_LIST_LOOP)) begin
            ctl.op = OP_CUR_NEXT;
          end else if (sts.cmd == CMD_PREV) begin
            ctl.op = OP_CUR_PREV;
          end
        end
      end
      S_DONE: begin
        if (!sts.out_busy) ctl.op = OP_OUT;
      end
      default: ctl.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
    end
  end

endmodule

// ===== src/shpl_dp.sv =====
// Datapath of the playlist sequencer: track, mode, order table, random word,
// configuration and result register. Depends on shpl_pkg and shpl_mod.
module shpl_dp import shpl_pkg::*; #(
  parameter int MAX_TRACKS = SHPL_MAX_TRACKS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [SEL_W-1:0]      in_track_sel,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  shpl_ctl_t             ctl,
  output shpl_sts_t             sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [TRACK_W-1:0]    out_track_index,
  output logic                  out_play_start,
  output logic [MODE_W-1:0]     out_play_mode
);

  localparam int PW = $clog2(MAX_TRACKS);
  localparam int NW = $clog2(MAX_TRACKS + 1);

  logic [PW-1:0] mem [MAX_TRACKS];

  logic [TC_W-1:0]   tc_r;
  logic [RNG_W-1:0]  rng_r, rng_nxt;
  logic [PW-1:0]     cur_r, pin_r, k_r, i_r, pos_r, a_r, rdata_r;
  logic [MODE_W-1:0] mode_r;
  logic [CMD_W-1:0]  cmd_r;
  logic [SEL_W-1:0]  sel_r;
  logic              ov_r;
  logic [TRACK_W-1:0] otrk_r;
  logic              ostart_r;
  logic [MODE_W-1:0] omode_r;

  logic [NW-1:0]    n;
  logic [NW-1:0]    nm1;
  logic [PW-1:0]    j;
  logic [PW-1:0]    raddr;
  logic [PW-1:0]    fill_val;
  logic [PW-1:0]    sel_clamp;
  logic [PW-1:0]    cur_clamp;
  logic             mod_start, mod_busy;
  logic [RNG_W-1:0] mod_dvd;
  logic [NW-1:0]    mod_dsr, mod_rem;
  logic             we;
  logic [PW-1:0]    waddr, wdata;

  // Track count clamped to the table size, never below one.
  always_comb begin
    if (tc_r == '0) n = NW'(1);
    else if (32'(tc_r) > MAX_TRACKS) n = NW'(MAX_TRACKS);
    else n = NW'(tc_r);
  end

  assign nm1       = n - NW'(1);
  assign j         = PW'(mod_rem) + PW'(1);
  assign rng_nxt   = xorshift32(rng_r);
  assign sel_clamp = (32'(sel_r) >= 32'(n)) ? '0 : PW'(sel_r);
  assign cur_clamp = (32'(cur_r) >= 32'(n)) ? '0 : cur_r;

  always_comb begin
    if (k_r == '0) fill_val = pin_r;
    else if (k_r == pin_r) fill_val = '0;
    else fill_val = k_r;
  end

  always_comb begin
    case (ctl.op)
      OP_RD_I:   raddr = i_r;
      OP_RD_J:   raddr = j;
      OP_RD_POS: raddr = pos_r;
      default:   raddr = k_r;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = k_r;
    wdata = fill_val;
    case (ctl.op)
      OP_FILL: we = 1'b1;
      OP_WR_I: begin
        we    = 1'b1;
        waddr = i_r;
        wdata = rdata_r;
      end
      OP_WR_J: begin
        we    = 1'b1;
        waddr = j;
        wdata = a_r;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign mod_start = (ctl.op == OP_MOD_RNG) || (ctl.op == OP_MOD_CUR) ||
                     (ctl.op == OP_MOD_ENT);

  always_comb begin
    case (ctl.op)
      OP_MOD_RNG: mod_dvd = rng_nxt;
      OP_MOD_ENT: mod_dvd = RNG_W'(rdata_r);
      default:    mod_dvd = RNG_W'(cur_r);
    endcase
    mod_dsr = (ctl.op == OP_MOD_RNG) ? NW'(i_r) : n;
  end

  shpl_mod #(.DSR_W(NW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dvd),
    .divisor  (mod_dsr),
    .busy     (mod_busy),
    .rem      (mod_rem)
  );

  // Control state: configuration, track, mode and the result handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r   <= TC_W'(1);
      rng_r  <= RNG_W'(1);
      cur_r  <= '0;
      mode_r <= MODE_LIST_LOOP;
      pos_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TRACK_COUNT: tc_r <= cfg_data[TC_W-1:0];
          CFG_RNG_SEED: rng_r <= (cfg_data == '0) ? RNG_W'(1) : cfg_data;
          default: tc_r <= tc_r;
        endcase
      end
      if (ctl.op == OP_OUT) ov_r <= 1'b1;
      else if (ov_r && out_ready) ov_r <= 1'b0;
      case (ctl.op)
        OP_START_SEL: cur_r <= sel_clamp;
        OP_MODE_INC:  mode_r <= mode_r + MODE_W'(1);
        OP_MOD_RNG:   rng_r <= rng_nxt;
        OP_POS_CLR:   pos_r <= '0;
        OP_POS_ONE:   pos_r <= PW'(1);
        OP_FIND_CMP: begin
          if (rdata_r == cur_r) pos_r <= k_r;
          else if (NW'(k_r) == nm1) pos_r <= '0;
        end
        OP_POS_FWD:   pos_r <= (NW'(pos_r) == nm1) ? '0 : pos_r + PW'(1);
        OP_POS_BACK:  pos_r <= (pos_r == '0) ? PW'(nm1) : pos_r - PW'(1);
        OP_SET_CUR:   cur_r <= PW'(mod_rem);
        OP_CUR_NEXT:  cur_r <= (NW'(cur_r) == nm1) ? '0 : cur_r + PW'(1);
        OP_CUR_PREV:  cur_r <= (cur_r == '0) ? PW'(nm1) : cur_r - PW'(1);
        default:      cur_r <= cur_r;
      endcase
    end
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LATCH: begin
        cmd_r <= in_cmd;
        sel_r <= in_track_sel;
      end
      OP_START_SEL: begin
        pin_r <= sel_clamp;
        k_r   <= '0;
      end
      OP_PIN_CUR: begin
        pin_r <= cur_clamp;
        k_r   <= '0;
      end
      OP_FILL: begin
        k_r <= k_r + PW'(1);
        i_r <= PW'(nm1);
      end
      OP_RD_J:      a_r <= rdata_r;
      OP_WR_J:      i_r <= i_r - PW'(1);
      OP_FIND_INIT: k_r <= '0;
      OP_FIND_CMP: begin
        if (rdata_r != cur_r) k_r <= k_r + PW'(1);
      end
      OP_OUT: begin
        otrk_r   <= TRACK_W'(cur_r);
        ostart_r <= ctl.play_start;
        omode_r  <= mode_r;
      end
      default: a_r <= a_r;
    endcase
  end

  assign sts.cmd         = cmd_r;
  assign sts.mode        = mode_r;
  assign sts.n_le1       = (n <= NW'(1));
  assign sts.i_le1       = (i_r <= PW'(1));
  assign sts.hit         = (rdata_r == cur_r);
  assign sts.k_last      = (NW'(k_r) == nm1);
  assign sts.pos_last    = ((NW + 1)'(pos_r) + (NW + 1)'(1) >= (NW + 1)'(n));
  assign sts.cur_lt_last = ((NW + 1)'(cur_r) + (NW + 1)'(1) < (NW + 1)'(n));
  assign sts.mod_busy    = mod_busy;
  assign sts.out_busy    = ov_r && !out_ready;

  assign out_valid       = ov_r;
  assign out_track_index = otrk_r;
  assign out_play_start  = ostart_r;
  assign out_play_mode   = omode_r;

endmodule

// ===== src/shuffle_playlist_sequencer.sv =====
// Playlist sequencer: one command beat in on in_ch, one result beat out on
// out_ch. A command gives start, next, previous, track ended or mode cycle;
// the result carries the current track, whether it should start playing
// and the play mode. The cfg_ port writes the track count and the seed.
// Items are handled one at a time; in_ch.ready is high only when idle.
// Simple steps are dominated by the wait on the remainder unit. A reshuffle
// over n tracks fills the order table and then swaps entries; each swap
// waits on that same remainder unit. A shuffle step first scans the order
// table entry by entry, up to n entries, through its single read port, then
// reads the new entry and reduces it in the remainder unit.
// Reset clears track, mode, position and result valid, sets the track
// count to one and the random word to one; the order table holds no
// meaning until the first reshuffle writes it.
// The result sits in an output register; while the receiver stalls the
// finished result is held and the next command waits in the done state.
module shuffle_playlist_sequencer import shpl_pkg::*; #(
  parameter int MAX_TRACKS = SHPL_MAX_TRACKS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  shpl_in_if.sink               in_ch,
  shpl_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  shpl_ctl_t ctl;
  shpl_sts_t sts;

  shpl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  shpl_dp #(.MAX_TRACKS(MAX_TRACKS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_cmd          (in_ch.cmd),
    .in_track_sel    (in_ch.track_sel),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .ctl             (ctl),
    .sts             (sts),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_track_index (out_ch.track_index),
    .out_play_start  (out_ch.play_start),
    .out_play_mode   (out_ch.play_mode)
  );

endmodule

// ===== src/shpl_checker.sv =====
// Port-level checker of the playlist sequencer, bound to the top level.
// Depends on shpl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module shpl_checker import shpl_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [CMD_W-1:0]   in_cmd,
  input logic               out_valid,
  input logic               out_ready,
  input logic [TRACK_W-1:0] out_track_index,
  input logic               out_play_start,
  input logic [MODE_W-1:0]  out_play_mode
);

  logic [CMD_W-1:0] pend_cmd_r, pend_cmd_nxt;
  logic [CMD_W-1:0] beat_cmd_r, beat_cmd_nxt;
  logic             held_r, held_nxt;

  // The command of the last accepted beat belongs to a result only when that
  // result first appears; a newer command may be accepted while it waits.
  assign pend_cmd_nxt = (in_valid && in_ready) ? in_cmd : pend_cmd_r;
  assign beat_cmd_nxt = (out_valid && !held_r) ? pend_cmd_r : beat_cmd_r;
  assign held_nxt     = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
    end else begin
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_cmd_r <= pend_cmd_nxt;
    beat_cmd_r <= beat_cmd_nxt;
  end

  `SHPL_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
  `SHPL_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_track_index) && $stable(out_play_start) && $stable(out_play_mode))
  `SHPL_ASSERT_IMP(a_quiet_cmds, out_valid && (beat_cmd_nxt == CMD_CYCLE_MODE ||
    beat_cmd_nxt > CMD_CYCLE_MODE), !out_play_start)
  `SHPL_ASSERT_IMP(a_play_cmds, out_valid && (beat_cmd_nxt == CMD_START ||
    beat_cmd_nxt == CMD_NEXT || beat_cmd_nxt == CMD_PREV), out_play_start)

endmodule

bind shuffle_playlist_sequencer shpl_checker u_shpl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_cmd          (in_ch.cmd),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_track_index (out_ch.track_index),
  .out_play_start  (out_ch.play_start),
  .out_play_mode   (out_ch.play_mode)
);

// ===== tb/testbench.sv =====
// Self-checking testbench of the playlist sequencer: a scoreboard class predicts each result.
// Depends on shpl_pkg, the channel interfaces in shpl_if and the top module.
module testbench;
  import shpl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [TRACK_W-1:0] track;
    logic               start;
    logic [MODE_W-1:0]  mode;
  } track_result_t;

  class playlist_scoreboard;
    int unsigned tcount, cur, md, pos, rword, span;
    int unsigned order [SHPL_MAX_TRACKS];
    track_result_t pending_q[$];
    int errors, mismatches, checked;

    function new();
      tcount = 1; cur = 0; md = 0; pos = 0; rword = 1; span = 0;
      errors = 0; mismatches = 0; checked = 0;
    endfunction

    function void configure(int unsigned tc, int unsigned seed);
      tcount = tc & 32'h3FF;
      rword = (seed == 0) ? 1 : seed;
    endfunction

    function int unsigned count_used();
      if (tcount < 1) return 1;
      if (tcount > SHPL_MAX_TRACKS) return SHPL_MAX_TRACKS;
      return tcount;
    endfunction

    function int unsigned draw();
      int unsigned x;
      x = rword;
      x = x ^ (x << 13);
      x = x ^ (x >> 17);
      x = x ^ (x << 5);
      rword = x;
      return x;
    endfunction

    function void reshuffle(int unsigned pin);
      int unsigned n, j, t;
      n = count_used();
      if (pin >= n) pin = 0;
      for (int unsigned i = 0; i < n; i++) order[i] = i;
      order[0] = pin;
      order[pin] = 0;
      for (int unsigned i = n - 1; i > 1; i--) begin
        j = 1 + (draw() % i);
        t = order[i]; order[i] = order[j]; order[j] = t;
      end
      pos = 0;
      if (n > span) span = n;
    endfunction

    function int unsigned locate(int unsigned trk);
      for (int unsigned i = 0; i < count_used(); i++)
        if (order[i] == trk) return i;
      return 0;
    endfunction

    function int unsigned shuffle_step(bit fwd, bit restart);
      int unsigned n;
      n = count_used();
      if (n <= 1) return cur;
      pos = locate(cur);
      if (fwd) begin
        if (restart && pos >= n - 1) begin
          reshuffle(cur);
          pos = 1;
          return order[1];
        end
        pos++;
        if (pos >= n) pos = 0;
      end else begin
        pos = (pos == 0) ? n - 1 : pos - 1;
      end
      return order[pos];
    endfunction

    // Works out the result of one accepted command beat.
    function void note_command(logic [CMD_W-1:0] c, logic [SEL_W-1:0] s);
      int unsigned n, cw, sel;
      bit st;
      track_result_t r;
      n = count_used();
      cw = cur % n;
      sel = 32'(s);
      st = 0;
      case (c)
        CMD_START: begin
          if (sel >= n) sel = 0;
          cur = sel;
          reshuffle(sel);
          st = 1;
        end
        CMD_NEXT: begin
          cur = ((md == MODE_SHUFFLE) ? shuffle_step(1, 0) : cw + 1) % n;
          st = 1;
        end
        CMD_PREV: begin
          cur = ((md == MODE_SHUFFLE) ? shuffle_step(0, 0) : cw + n - 1) % n;
          st = 1;
        end
        CMD_TRACK_END: begin
          if (md == MODE_LIST_LOOP) begin
            cur = (cw + 1) % n; st = 1;
          end else if (md == MODE_SHUFFLE) begin
            cur = shuffle_step(1, 1) % n; st = 1;
          end else if (md == MODE_SINGLE_LOOP) begin
            cur = cw; st = 1;
          end else if (cur < n - 1) begin
            cur = (cur + 1) % n; st = 1;
          end
        end
        CMD_CYCLE_MODE: begin
          md = (md + 1) & 3;
          if (md == MODE_SHUFFLE) reshuffle(cur);
        end
        default: ;
      endcase
      r.track = cur[TRACK_W-1:0];
      r.start = st;
      r.mode = md[MODE_W-1:0];
      pending_q.push_back(r);
    endfunction

    function void check_result(track_result_t got);
      track_result_t w;
      checked++;
      if (pending_q.size() == 0) begin
        errors++;
        $display("unexpected result beat: track %0d start %0d mode %0d",
                 got.track, got.start, got.mode);
        return;
      end
      w = pending_q.pop_front();
      if (got !== w) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected track %0d start %0d mode %0d, got %0d %0d %0d",
                   w.track, w.start, w.mode, got.track, got.start, got.mode);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_TRACK_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  bit idling = 1'b1;
  int phases = 0;

  shpl_in_if in_ch ();
  shpl_out_if out_ch ();
  playlist_scoreboard sb = new();

  always #5 clk = ~clk;

  shuffle_playlist_sequencer dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_START;
    in_ch.track_sel = '0;
    out_ch.ready = 1'b0;
  end

  // Result side: check every accepted beat, stall at random while idling is set.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.track_index, out_ch.play_start, out_ch.play_mode});
    out_ch.ready <= !idling || ($urandom_range(99) >= 16);
  end

  task automatic send_command(logic [CMD_W-1:0] c, logic [SEL_W-1:0] s);
    if (idling && $urandom_range(99) < 16) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= c;
    in_ch.track_sel <= s;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_command(c, s);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Both registers are written back to back while the block is idle.
  task automatic write_config(int unsigned tc, int unsigned seed);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= CFG_TRACK_COUNT;
    cfg_data <= tc;
    @(posedge clk);
    cfg_index <= CFG_RNG_SEED;
    cfg_data <= seed;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.configure(tc, seed);
    phases++;
  endtask

  task automatic random_command();
    int unsigned n, w;
    logic [CMD_W-1:0] c;
    logic [SEL_W-1:0] s;
    n = sb.count_used();
    w = $urandom_range(99);
    if (w < 10) c = CMD_START;
    else if (w < 30) c = CMD_NEXT;
    else if (w < 45) c = CMD_PREV;
    else if (w < 77) c = CMD_TRACK_END;
    else if (w < 94) c = CMD_CYCLE_MODE;
    else c = CMD_W'($urandom_range(5, 7));
    s = ($urandom_range(9) < 7) ? SEL_W'($urandom_range(n - 1)) : SEL_W'($urandom_range(511));
    send_command(c, s);
  endtask

  // A grown playlist would make a shuffle step scan entries no reshuffle has written yet.
  task automatic guard_order();
    if (sb.md == MODE_SHUFFLE && sb.count_used() > sb.span)
      send_command(CMD_START, SEL_W'($urandom_range(sb.count_used() - 1)));
  endtask

  task automatic random_phase(int unsigned tc, int unsigned seed, int items);
    write_config(tc, seed);
    guard_order();
    for (int k = 0; k < items; k++) random_command();
  endtask

  initial begin
    int unsigned tc;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // One track after reset: unknown codes, and shuffle steps that keep the track.
    send_command(3'd5, 9'd0);
    send_command(3'd7, 9'd511);
    send_command(CMD_CYCLE_MODE, 9'd0);
    send_command(CMD_NEXT, 9'd0);
    send_command(CMD_TRACK_END, 9'd0);
    send_command(CMD_CYCLE_MODE, 9'd0);
    send_command(CMD_CYCLE_MODE, 9'd0);
    send_command(CMD_CYCLE_MODE, 9'd0);

    // Eight tracks, zero seed: out-of-range start, every mode, end of list play.
    write_config(8, 0);
    send_command(CMD_START, 9'd511);
    send_command(CMD_START, 9'd3);
    send_command(CMD_NEXT, 9'd0);
    send_command(CMD_PREV, 9'd0);
    send_command(CMD_PREV, 9'd0);
    send_command(CMD_CYCLE_MODE, 9'd0);
    for (int k = 0; k < 9; k++) send_command(CMD_TRACK_END, 9'd0);
    send_command(CMD_PREV, 9'd0);
    send_command(CMD_CYCLE_MODE, 9'd0);
    send_command(CMD_TRACK_END, 9'd0);
    send_command(CMD_CYCLE_MODE, 9'd0);
    send_command(CMD_START, 9'd7);
    send_command(CMD_TRACK_END, 9'd0);
    send_command(CMD_NEXT, 9'd0);
    send_command(CMD_CYCLE_MODE, 9'd0);

    // Lowered count leaves the current track and table entries stale.
    write_config(3, 32'hFFFF_FFFF);
    send_command(CMD_NEXT, 9'd0);
    send_command(CMD_CYCLE_MODE, 9'd0);
    send_command(CMD_TRACK_END, 9'd0);

    // Largest playlists reshuffle slowly, so they get only a few beats.
    random_phase(1023, $urandom, 6);
    random_phase(512, $urandom, 5);
    random_phase(0, $urandom, 12);
    random_phase(2, $urandom, 20);

    idling = 1'b0;
    random_phase(6, $urandom, 60);
    idling = 1'b1;

    for (int p = 0; p < 17; p++) begin
      tc = ($urandom_range(9) == 0) ? $urandom_range(25, 70) : $urandom_range(1, 16);
      random_phase(tc, $urandom, 24);
      if (p == 8) begin
        drain();
        for (int k = 0; k < 6; k++) random_command();
      end
    end

    drain();
    $display("Covered %0d result beats over %0d register settings, all modes and commands.",
             sb.checked, phases);
    $display("Track counts ranged from zero to 1023, including reshuffles of 512 tracks.");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
